// ===== sv/cps_pkg.sv =====
//------------------------------------------------------------------------------
// cps_pkg
// Shared types, codes and the ranking function of the process scheduler.
//------------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int T_W     = 18;
	localparam int PID_W   = 14;
	localparam int REM_W   = 10;
	localparam int ARR_W   = 16;
	localparam int PRIO_W  = 8;
	localparam int ALG_W   = 3;
	localparam int TQ_W    = 10;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_DECIDE = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// status codes
	localparam logic [1:0] ST_SEG   = 2'd0;
	localparam logic [1:0] ST_LOADED = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// algorithm codes
	localparam logic [ALG_W-1:0] ALG_FCFS  = 3'd0;
	localparam logic [ALG_W-1:0] ALG_SJF   = 3'd1;
	localparam logic [ALG_W-1:0] ALG_PRIO  = 3'd2;
	localparam logic [ALG_W-1:0] ALG_PSJF  = 3'd3;
	localparam logic [ALG_W-1:0] ALG_PPRIO = 3'd4;
	localparam logic [ALG_W-1:0] ALG_RR    = 3'd5;

	// configuration register indexes
	localparam logic CFG_ALG = 1'b0;
	localparam logic CFG_TQ  = 1'b1;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [PID_W-1:0]  pid;
		logic [REM_W-1:0]  burst;
		logic [ARR_W-1:0]  arrival;
		logic [PRIO_W-1:0] prio;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PID_W-1:0] seg_pid;
		logic [T_W-1:0]   seg_start;
		logic [T_W-1:0]   seg_end;
		logic             extends_previous;
		logic             last;
	} result_t;

	// one table entry; arrival grows to full time width under round robin
	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [REM_W-1:0]  rem;
		logic [T_W-1:0]    arr;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic             rotate;
		logic             remove;
		logic             write;
		logic [IDX_W-1:0] idx;
		entry_t           data;
	} cell_ctl_t;

	// true when entry a ranks ahead of entry b under the given algorithm
	function automatic logic beats(input logic [ALG_W-1:0] alg, input entry_t a,
		input entry_t b);
		logic r;
		unique case (alg)
			ALG_SJF: begin
				if (a.rem != b.rem) r = a.rem < b.rem;
				else if (a.arr != b.arr) r = a.arr < b.arr;
				else r = a.prio > b.prio;
			end
			ALG_PSJF: begin
				if (a.rem != b.rem) r = a.rem < b.rem;
				else if (a.prio != b.prio) r = a.prio > b.prio;
				else r = a.arr < b.arr;
			end
			ALG_PRIO, ALG_PPRIO: begin
				if (a.prio != b.prio) r = a.prio > b.prio;
				else r = a.arr < b.arr;
			end
			default: begin
				if (a.arr != b.arr) r = a.arr < b.arr;
				else r = a.prio > b.prio;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/cpu_process_scheduler.sv =====
//------------------------------------------------------------------------------
// cpu_process_scheduler
// Process table held in a row of cells; each decide emits the next segment.
//
// channel   signals                              handshake
// command   start, busy, cmd                     start & !busy
// result    result_valid, result                 one-cycle strobe
// config    cfg_we, cfg_index, cfg_data          cfg_we
//
// load, clear and an empty decide stay in idle; the word of a load or an empty
// decide shows next cycle, a clear gives no word. a decide rotates the row once
// to pick, sjf and priority rotate once more first for the earliest arrival;
// then the decide and run states emit, except a preemptive idle word, which ends in the decide state.
// reset empties the table and zeroes time; table contents need no reset.
// results cannot be stalled.
//------------------------------------------------------------------------------
`default_nettype none

module cpu_process_scheduler (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire cps_pkg::cmd_t             cmd,
	output logic                           result_valid,
	output cps_pkg::result_t               result,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [cps_pkg::TQ_W-1:0]  cfg_data
);
	import cps_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MIN  = 5'b00010,
		S_PICK = 5'b00100,
		S_DEC  = 5'b01000,
		S_RUN  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  scan_q;
	logic              found_q;
	entry_t            best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [T_W-1:0]    min_q;
	logic [T_W-1:0]    now_q;
	logic [CNT_W-1:0]  count_q;
	logic [ALG_W-1:0]  alg_q;
	logic [TQ_W-1:0]   tq_q;
	logic [PID_W-1:0]  last_pid_q;
	logic              have_q;
	logic              result_valid_q;
	result_t           result_q;

	entry_t            cells [ENTRIES];
	cell_ctl_t         ctl;

	logic [ALG_W-1:0]  alg;
	logic              preempt;
	logic              limited;
	logic [T_W-1:0]    limit;
	entry_t            head;
	logic              head_valid;
	logic              eligible;
	logic              accept;
	logic [REM_W-1:0]  quantum;
	logic [REM_W-1:0]  slice;
	logic [T_W-1:0]    run_end;
	logic              run_remove;
	entry_t            upd;

	// row of cells, rotating towards cell zero
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		cps_cell u_cell (
			.clk (clk),
			.ctl (ctl),
			.idx (IDX_W'(i)),
			.nxt (cells[(i + 1) % ENTRIES]),
			.ent (cells[i])
		);
	end

	// decode of the mode
	assign alg     = (alg_q > ALG_RR) ? ALG_FCFS : alg_q;
	assign preempt = (alg == ALG_PSJF) || (alg == ALG_PPRIO);
	assign limited = (alg == ALG_SJF) || (alg == ALG_PRIO) || preempt;
	assign limit   = ((alg == ALG_SJF) || (alg == ALG_PRIO)) ?
		((now_q > min_q) ? now_q : min_q) : now_q;

	// scanned entry at the head of the row
	assign head       = cells[0];
	assign head_valid = CNT_W'(scan_q) < count_q;
	assign eligible   = head_valid && (!limited || head.arr <= limit);
	assign accept     = start && !busy;

	// slice length and table update for the chosen entry
	assign quantum = (tq_q == '0) ? REM_W'(1) : tq_q;
	always_comb begin
		upd = best_q;
		if (preempt) begin
			slice      = REM_W'(1);
			run_remove = best_q.rem <= REM_W'(1);
			upd.rem    = best_q.rem - REM_W'(1);
		end else if (alg == ALG_RR) begin
			slice      = (best_q.rem < quantum) ? best_q.rem : quantum;
			run_remove = best_q.rem <= quantum;
			upd.rem    = best_q.rem - quantum;
		end else begin
			slice      = best_q.rem;
			run_remove = 1'b1;
		end
		run_end = now_q + T_W'(slice);
		// round robin requeues the entry at the slice end
		if (alg == ALG_RR) begin
			upd.arr = run_end;
		end
	end

	// control to the row
	always_comb begin
		ctl        = '0;
		ctl.rotate = (state_q == S_MIN) || (state_q == S_PICK);
		if (state_q == S_IDLE) begin
			ctl.write     = accept && cmd.req_type == REQ_LOAD &&
				count_q < CNT_W'(ENTRIES);
			ctl.idx       = count_q[IDX_W-1:0];
			ctl.data.pid  = cmd.pid;
			ctl.data.rem  = cmd.burst;
			ctl.data.arr  = T_W'(cmd.arrival);
			ctl.data.prio = cmd.prio;
		end else if (state_q == S_RUN) begin
			ctl.remove = run_remove;
			ctl.write  = !run_remove;
			ctl.idx    = best_idx_q;
			ctl.data   = upd;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= ALG_FCFS;
			tq_q  <= TQ_W'(5);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ALG: alg_q <= cfg_data[ALG_W-1:0];
				CFG_TQ:  tq_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, scan and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			scan_q         <= '0;
			found_q        <= 1'b0;
			best_idx_q     <= '0;
			min_q          <= '1;
			now_q          <= '0;
			count_q        <= '0;
			last_pid_q     <= '0;
			have_q         <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						result_q <= '0;
						unique case (cmd.req_type)
							REQ_LOAD: begin
								result_valid_q <= 1'b1;
								result_q.last  <= 1'b1;
								if (count_q < CNT_W'(ENTRIES)) begin
									result_q.status <= ST_LOADED;
									count_q         <= count_q + CNT_W'(1);
								end else begin
									result_q.status <= ST_FULL;
								end
							end
							REQ_CLEAR: begin
								count_q    <= '0;
								now_q      <= '0;
								last_pid_q <= '0;
								have_q     <= 1'b0;
							end
							REQ_DECIDE: begin
								if (count_q == '0) begin
									result_valid_q  <= 1'b1;
									result_q.status <= ST_EMPTY;
									result_q.last   <= 1'b1;
								end else begin
									scan_q  <= '0;
									found_q <= 1'b0;
									min_q   <= '1;
									state_q <= ((alg == ALG_SJF) || (alg == ALG_PRIO)) ?
										S_MIN : S_PICK;
								end
							end
							default: ;
						endcase
					end
				end
				S_MIN, S_PICK: begin
					if (head_valid && head.arr < min_q) begin
						min_q <= head.arr;
					end
					if (state_q == S_PICK && eligible &&
						(!found_q || beats(alg, head, best_q))) begin
						found_q    <= 1'b1;
						best_q     <= head;
						best_idx_q <= scan_q;
					end
					scan_q <= scan_q + IDX_W'(1);
					if (scan_q == IDX_W'(ENTRIES - 1)) begin
						scan_q  <= '0;
						state_q <= (state_q == S_MIN) ? S_PICK : S_DEC;
					end
				end
				S_DEC: begin
					result_q <= '0;
					if (preempt && !found_q) begin
						result_valid_q            <= 1'b1;
						result_q.seg_start        <= now_q;
						result_q.seg_end          <= min_q;
						result_q.extends_previous <= have_q && last_pid_q == '0;
						result_q.last             <= 1'b1;
						last_pid_q                <= '0;
						have_q                    <= 1'b1;
						now_q                     <= min_q;
						state_q                   <= S_IDLE;
					end else begin
						if (!preempt && best_q.arr > now_q) begin
							result_valid_q            <= 1'b1;
							result_q.seg_start        <= now_q;
							result_q.seg_end          <= best_q.arr;
							result_q.extends_previous <= have_q && last_pid_q == '0;
							last_pid_q                <= '0;
							have_q                    <= 1'b1;
							now_q                     <= best_q.arr;
						end
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					result_valid_q            <= 1'b1;
					result_q.status           <= ST_SEG;
					result_q.seg_pid          <= best_q.pid;
					result_q.seg_start        <= now_q;
					result_q.seg_end          <= run_end;
					result_q.extends_previous <= have_q && last_pid_q == best_q.pid;
					result_q.last             <= 1'b1;
					last_pid_q                <= best_q.pid;
					have_q                    <= 1'b1;
					now_q                     <= run_end;
					if (run_remove) begin
						count_q <= count_q - CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = state_q != S_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// table fill never exceeds the row length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	// the run step always delivers the closing segment
	a_run_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |=> result_valid && result.last && result.status == ST_SEG)
		else $error("run step without final segment");

	// a decide on a non-empty table starts a scan
	a_decide_scans: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.req_type == REQ_DECIDE && count_q != '0 |=> busy)
		else $error("decide did not start a scan");

	// a non-segment word is always the final one
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_SEG |-> result.last)
		else $error("status word not marked last");

	// pick phase ends with a choice unless preemptive
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEC && !preempt |-> found_q)
		else $error("no entry chosen");

endmodule

`default_nettype wire

// ===== sv/cps_cell.sv =====
//------------------------------------------------------------------------------
// cps_cell
// One slot of the process table; loads, updates, shifts and rotates.
//------------------------------------------------------------------------------
`default_nettype none

module cps_cell (
	input  wire logic                      clk,
	input  wire cps_pkg::cell_ctl_t        ctl,
	input  wire logic [cps_pkg::IDX_W-1:0] idx,
	input  wire cps_pkg::entry_t           nxt,
	output cps_pkg::entry_t                ent
);
	import cps_pkg::*;

	entry_t ent_q;

	// rotate takes the neighbor; remove closes the gap above the removed slot
	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			ent_q <= nxt;
		end else if (ctl.remove && idx >= ctl.idx) begin
			ent_q <= nxt;
		end else if (ctl.write && idx == ctl.idx) begin
			ent_q <= ctl.data;
		end
	end

	assign ent = ent_q;

endmodule

`default_nettype wire
